[hw/rtl/assert_macros.svh]
// Assertion macros shared by the filter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on an explicit clock and active-low reset.
`define C3_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on the module's clk_i / rst_ni.
`define C3_ASSERT(lbl, prop, msg) `C3_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/c3lbf_pkg.sv]
// Types, constants and helpers for the 3x3 line-buffer convolution filter.
// No dependencies; imported by every module of the filter.
`default_nettype none

package c3lbf_pkg;

  // Geometry
  localparam int MAX_WIDTH     = 1024;
  localparam int KERNEL_DIM    = 3;
  localparam int WIN_SIZE      = KERNEL_DIM * KERNEL_DIM;
  localparam int STORE_LEN     = MAX_WIDTH - KERNEL_DIM;
  localparam int ADDR_W        = $clog2(STORE_LEN);
  localparam int LEN_W         = $clog2(STORE_LEN + 1);
  localparam int MIN_WIDTH     = 4;

  // Field widths
  localparam int PIX_W         = 8;
  localparam int COEF_W        = 8;
  localparam int KROW_W        = KERNEL_DIM * COEF_W;
  localparam int WIDTH_W       = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = KROW_W;
  localparam int LINE_WIDTH_RST = 1024;

  // Arithmetic
  localparam int PROD_W        = PIX_W + COEF_W + 1;
  localparam int SUM_W         = 20;
  localparam int SHIFT         = 4;

  typedef logic [PIX_W-1:0]               pix_t;
  typedef pix_t [WIN_SIZE-1:0]            win_t;
  typedef logic [KROW_W-1:0]              krow_t;
  typedef krow_t [KERNEL_DIM-1:0]         kernel_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef prod_t [WIN_SIZE-1:0]           prods_t;
  typedef logic [LEN_W-1:0]               len_t;
  typedef logic [ADDR_W-1:0]              addr_t;
  typedef logic [WIDTH_W-1:0]             width_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KROW0  = 2'd0,
    REG_KROW1  = 2'd1,
    REG_KROW2  = 2'd2,
    REG_LWIDTH = 2'd3
  } cfg_reg_e;

  // Pipeline advance strobes, one per stage boundary
  typedef struct packed {
    logic in_acc;   // beat enters stage A
    logic a_adv;    // stage A moves to B (window shift, line store write)
    logic b_adv;    // stage B moves to C (products)
    logic c_adv;    // stage C moves to D (sum and clamp)
  } pipe_ctrl_t;

  // Line store length for a programmed width, width clamped to MIN..MAX
  function automatic len_t store_len(width_t w);
    int unsigned wc;
    wc = 32'(w);
    if (wc < MIN_WIDTH) wc = MIN_WIDTH;
    if (wc > MAX_WIDTH) wc = MAX_WIDTH;
    return LEN_W'(wc - KERNEL_DIM);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/c3lbf_line_store.sv]
// Two line stores sharing one circular pointer, with a fill count for reset.
// Depends on c3lbf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module c3lbf_line_store
  import c3lbf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pipe_ctrl_t ctrl_i,
  input  wire len_t       len_i,
  input  wire pix_t       tap_mid_i,
  input  wire pix_t       tap_bot_i,
  output logic [PIX_W-1:0] from0_o,
  output logic [PIX_W-1:0] from1_o
);

  logic [2*PIX_W-1:0] mem_q [STORE_LEN];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] wr_word;
  logic               rd_vld_q;
  addr_t              ptr_q, ptr_d;
  addr_t              a_addr_q;
  addr_t              rd_addr;
  len_t               fill_q, fill_d;
  len_t               rd_inc;
  logic               bypass;

  // Wrap the pointer if the width shrank, then compute the next position
  always_comb begin
    rd_addr = (LEN_W'(ptr_q) >= len_i) ? '0 : ptr_q;
    rd_inc  = LEN_W'(rd_addr) + LEN_W'(1);
    ptr_d   = (rd_inc >= len_i) ? '0 : ADDR_W'(rd_inc);
  end

  // Row 1 leftmost pixel feeds store 0, row 2 leftmost feeds store 1
  assign wr_word = {tap_bot_i, tap_mid_i};
  assign bypass  = ctrl_i.a_adv && (a_addr_q == rd_addr);

  // Written entries always form a prefix of the store; extend it on write
  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.a_adv && (LEN_W'(a_addr_q) == fill_q)) begin
      fill_d = fill_q + LEN_W'(1);
    end
  end

  // Pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (ctrl_i.in_acc) begin
        ptr_q <= ptr_d;
      end
    end
  end

  // Address of the beat held in stage A
  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_acc) begin
      a_addr_q <= rd_addr;
    end
  end

  // Write the leaving window pixels when stage A advances
  always_ff @(posedge clk_i) begin
    if (ctrl_i.a_adv) begin
      mem_q[a_addr_q] <= wr_word;
    end
  end

  // Registered read; forward a same-cycle write to the same entry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_acc) begin
      rd_q     <= bypass ? wr_word : mem_q[rd_addr];
      rd_vld_q <= bypass || (LEN_W'(rd_addr) < fill_q);
    end
  end

  // Entries never written read as zero
  assign from0_o = rd_vld_q ? rd_q[PIX_W-1:0]       : '0;
  assign from1_o = rd_vld_q ? rd_q[2*PIX_W-1:PIX_W] : '0;

  `C3_ASSERT(a_fill_range, fill_q <= LEN_W'(STORE_LEN), "fill count beyond store length")
  `C3_ASSERT(a_fill_covers, ctrl_i.a_adv |=> fill_q > LEN_W'($past(a_addr_q)), "fill misses write")
  `C3_ASSERT(a_addr_in_len, ctrl_i.in_acc |=> LEN_W'(a_addr_q) < $past(len_i), "address past end")

endmodule

`default_nettype wire

[hw/rtl/c3lbf_window.sv]
// 3x3 window registers and the registered kernel products.
// Depends on c3lbf_pkg.
`default_nettype none

module c3lbf_window
  import c3lbf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pipe_ctrl_t ctrl_i,
  input  wire kernel_t    kernel_i,
  input  wire pix_t       pix_i,
  input  wire pix_t       from0_i,
  input  wire pix_t       from1_i,
  output pix_t            tap_mid_o,
  output pix_t            tap_bot_o,
  output prods_t          prod_o
);

  win_t   win_q, win_d;
  prods_t prod_q;
  pix_t   feed [KERNEL_DIM];

  assign feed[0] = from0_i;
  assign feed[1] = from1_i;
  assign feed[2] = pix_i;

  // Shift every row left by one; new pixels enter at the right end
  always_comb begin
    for (int r = 0; r < KERNEL_DIM; r++) begin
      for (int c = 0; c < KERNEL_DIM - 1; c++) begin
        win_d[r*KERNEL_DIM + c] = win_q[r*KERNEL_DIM + c + 1];
      end
      win_d[r*KERNEL_DIM + KERNEL_DIM - 1] = feed[r];
    end
  end

  // Window state, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.a_adv) begin
      win_q <= win_d;
    end
  end

  // Pixels leaving the left end of the middle and bottom rows
  assign tap_mid_o = win_q[KERNEL_DIM];
  assign tap_bot_o = win_q[2*KERNEL_DIM];

  // One signed product per window position
  always_ff @(posedge clk_i) begin
    if (ctrl_i.b_adv) begin
      for (int r = 0; r < KERNEL_DIM; r++) begin
        for (int c = 0; c < KERNEL_DIM; c++) begin
          prod_q[r*KERNEL_DIM + c] <=
            $signed({1'b0, win_q[r*KERNEL_DIM + c]}) *
            $signed(kernel_i[r][COEF_W*c +: COEF_W]);
        end
      end
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

[hw/rtl/c3lbf_mac.sv]
// Sum of the nine products, arithmetic shift and clamp into the result register.
// Depends on c3lbf_pkg.
`default_nettype none

module c3lbf_mac
  import c3lbf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire pipe_ctrl_t ctrl_i,
  input  wire prods_t     prod_i,
  output pix_t            pix_o
);

  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] shf;
  pix_t                    res;
  pix_t                    pix_q;

  // Add the products sign-extended to the accumulator width
  always_comb begin
    acc = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      acc = acc + {{(SUM_W-PROD_W){prod_i[i][PROD_W-1]}}, prod_i[i]};
    end
    shf = acc >>> SHIFT;
    if (acc[SUM_W-1]) begin
      res = '0;
    end else if (|shf[SUM_W-1:PIX_W]) begin
      res = '1;
    end else begin
      res = shf[PIX_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.c_adv) begin
      pix_q <= res;
    end
  end

  assign pix_o = pix_q;

endmodule

`default_nettype wire

[hw/rtl/conv3x3_line_buffer_filter.sv]
// 3x3 convolution over a raster pixel stream: one pixel per clock unless the output
// stalls; four stages (input/line-store read, window shift, products, sum and clamp).
// An accepted beat passes the window, product and result registers to out_valid_o.
// Throughput: one beat per cycle; a stage holds while the next is full and held.
// Reset clears the window, pointer and line-store fill count (no clearing pass);
// kernels reset to zero and line width to 1024.
`default_nettype none

module conv3x3_line_buffer_filter
  import c3lbf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // pixel input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIX_W-1:0]      pixel_in_i,
  input  wire logic                  last_pixel_i,
  // pixel output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [PIX_W-1:0]           pixel_out_o,
  output logic                       last_out_o
);

  kernel_t    kernel_q;
  width_t     line_width_q;
  len_t       line_len;

  logic       a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  logic       a_ready, b_ready, c_ready, d_ready;
  pix_t       a_pix_q;
  logic       a_last_q, b_last_q, c_last_q, d_last_q;
  pipe_ctrl_t ctrl;

  pix_t       from0, from1;
  pix_t       tap_mid, tap_bot;
  prods_t     prods;
  pix_t       res_pix;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q     <= '0;
      line_width_q <= WIDTH_W'(LINE_WIDTH_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KROW0:  kernel_q[0]  <= cfg_wdata_i;
        REG_KROW1:  kernel_q[1]  <= cfg_wdata_i;
        REG_KROW2:  kernel_q[2]  <= cfg_wdata_i;
        REG_LWIDTH: line_width_q <= cfg_wdata_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign line_len = store_len(line_width_q);

  // Stage readiness: a stage takes a beat when empty or when it drains
  always_comb begin
    d_ready     = !d_valid_q || !out_stall_i;
    c_ready     = !c_valid_q || d_ready;
    b_ready     = !b_valid_q || c_ready;
    a_ready     = !a_valid_q || b_ready;
    ctrl.in_acc = in_valid_i && a_ready;
    ctrl.a_adv  = a_valid_q && b_ready;
    ctrl.b_adv  = b_valid_q && c_ready;
    ctrl.c_adv  = c_valid_q && d_ready;
  end

  assign in_stall_o = !a_ready;

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      a_valid_q <= ctrl.in_acc || (a_valid_q && !b_ready);
      b_valid_q <= ctrl.a_adv  || (b_valid_q && !c_ready);
      c_valid_q <= ctrl.b_adv  || (c_valid_q && !d_ready);
      d_valid_q <= ctrl.c_adv  || (d_valid_q && out_stall_i);
    end
  end

  // Input beat and last flag along the stages
  always_ff @(posedge clk_i) begin
    if (ctrl.in_acc) begin
      a_pix_q  <= pixel_in_i;
      a_last_q <= last_pixel_i;
    end
    if (ctrl.a_adv) b_last_q <= a_last_q;
    if (ctrl.b_adv) c_last_q <= b_last_q;
    if (ctrl.c_adv) d_last_q <= c_last_q;
  end

  c3lbf_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .len_i     (line_len),
    .tap_mid_i (tap_mid),
    .tap_bot_i (tap_bot),
    .from0_o   (from0),
    .from1_o   (from1)
  );

  c3lbf_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .kernel_i  (kernel_q),
    .pix_i     (a_pix_q),
    .from0_i   (from0),
    .from1_i   (from1),
    .tap_mid_o (tap_mid),
    .tap_bot_o (tap_bot),
    .prod_o    (prods)
  );

  c3lbf_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .prod_i (prods),
    .pix_o  (res_pix)
  );

  assign out_valid_o = d_valid_q;
  assign pixel_out_o = res_pix;
  assign last_out_o  = d_last_q;

endmodule

`default_nettype wire

[verif/conv3x3_line_buffer_filter_tb.sv]
// Self-checking testbench for the 3x3 line-buffer convolution filter.
// Needs only the filter RTL and c3lbf_pkg; predicts each beat from its own window model.
`timescale 1ns / 1ps

module conv3x3_line_buffer_filter_tb;
  import c3lbf_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } px_beat_t;

  typedef enum int {KS_SMOOTH, KS_FULL, KS_EDGE, KS_EXTREME} kern_style_e;
  typedef enum int {PS_UNIFORM, PS_RAMP, PS_EXTREME} pix_style_e;

  // DUT ports
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = REG_KROW0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_in_i   = '0;
  logic                  last_pixel_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [PIX_W-1:0]      pixel_out_o;
  logic                  last_out_o;

  // Window and line-store model
  logic [PIX_W-1:0]  win_px     [WIN_SIZE];
  logic [PIX_W-1:0]  row_store0 [STORE_LEN];
  logic [PIX_W-1:0]  row_store1 [STORE_LEN];
  int unsigned       rd_ptr;
  logic [KROW_W-1:0] kern_row   [KERNEL_DIM];
  logic [WIDTH_W-1:0] img_width;

  px_beat_t pending_px[$];
  bit       idle_en      = 1'b1;
  int       fail_cnt     = 0;
  int       items_sent   = 0;
  int       results_seen = 0;
  int       phases       = 0;
  int       stall_left   = 0;

  conv3x3_line_buffer_filter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .last_pixel_i (last_pixel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .last_out_o   (last_out_o)
  );

  always #5 clk_i = ~clk_i;

  // Line-store length for the programmed width, width clamped to 4..MAX_WIDTH
  function automatic int unsigned active_len();
    int unsigned w;
    w = 32'(img_width);
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w - KERNEL_DIM;
  endfunction

  // Shift one pixel through the model and return the filtered value
  function automatic logic [PIX_W-1:0] filter_pixel(logic [PIX_W-1:0] pix);
    int unsigned len, p;
    logic [PIX_W-1:0] up0, up1;
    logic signed [COEF_W-1:0] coef;
    int acc, q;
    len = active_len();
    p = rd_ptr;
    if (p >= len) p = 0;
    up0 = row_store0[p];
    up1 = row_store1[p];
    row_store0[p] = win_px[3];
    row_store1[p] = win_px[6];
    p++;
    if (p >= len) p = 0;
    rd_ptr = p;
    win_px[0] = win_px[1]; win_px[1] = win_px[2]; win_px[2] = up0;
    win_px[3] = win_px[4]; win_px[4] = win_px[5]; win_px[5] = up1;
    win_px[6] = win_px[7]; win_px[7] = win_px[8]; win_px[8] = pix;
    acc = 0;
    for (int r = 0; r < KERNEL_DIM; r++) begin
      for (int c = 0; c < KERNEL_DIM; c++) begin
        coef = kern_row[r][COEF_W*c +: COEF_W];
        acc += int'(win_px[r*KERNEL_DIM+c]) * int'(coef);
      end
    end
    // floor divide by 16, then clamp to the pixel range
    q = acc >>> SHIFT;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return 8'(q);
  endfunction

  function automatic logic [KROW_W-1:0] pack_row(int c0, int c1, int c2);
    return {8'(c2), 8'(c1), 8'(c0)};
  endfunction

  function automatic int rand_coef(kern_style_e ks);
    case (ks)
      KS_SMOOTH: return $urandom_range(0, 4);
      KS_FULL:   return int'($urandom_range(0, 255)) - 128;
      KS_EDGE:   return int'($urandom_range(0, 16)) - 8;
      default: begin
        case ($urandom_range(0, 4))
          0:       return -128;
          1:       return -1;
          2:       return 0;
          3:       return 1;
          default: return 127;
        endcase
      end
    endcase
  endfunction

  // Send one pixel beat; optional gap first, then hold until accepted
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_in_i   <= pix;
    last_pixel_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    pending_px.push_back(px_beat_t'{pix: filter_pixel(pix), last: last});
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_KROW0:  kern_row[0] = data;
      REG_KROW1:  kern_row[1] = data;
      REG_KROW2:  kern_row[2] = data;
      REG_LWIDTH: img_width   = data[WIDTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_kernel(input logic [KROW_W-1:0] k0, k1, k2);
    write_reg(REG_KROW0, k0);
    write_reg(REG_KROW1, k1);
    write_reg(REG_KROW2, k2);
  endtask

  // One configuration phase with random kernel, given width and pixel pattern
  task automatic run_phase(input int n_items, input logic [WIDTH_W-1:0] width,
                           input bit with_idle);
    kern_style_e ks;
    pix_style_e  ps;
    logic [PIX_W-1:0] pix;
    logic [31:0] junk;
    int step;
    drain_pipe();
    ks = kern_style_e'($urandom_range(0, 3));
    for (int r = 0; r < KERNEL_DIM; r++) begin
      if ($urandom_range(0, 3) != 0)
        write_reg(cfg_reg_e'(r), pack_row(rand_coef(ks), rand_coef(ks), rand_coef(ks)));
    end
    // upper data bits are junk; only the low width bits land
    junk = $urandom;
    write_reg(REG_LWIDTH, {junk[12:0], width});
    idle_en = with_idle;
    ps   = pix_style_e'($urandom_range(0, 2));
    pix  = 8'($urandom);
    step = int'($urandom_range(0, 6)) - 3;
    for (int i = 0; i < n_items; i++) begin
      case (ps)
        PS_UNIFORM: pix = 8'($urandom);
        PS_RAMP:    pix = pix + 8'(step);
        default: begin
          case ($urandom_range(0, 3))
            0:       pix = 8'd0;
            1:       pix = 8'd255;
            2:       pix = 8'd1;
            default: pix = 8'd254;
          endcase
        end
      endcase
      send_pixel(pix, (i == n_items - 1) || ($urandom_range(0, 49) == 0));
    end
    phases++;
  endtask

  // Zero kernels after reset give zero output; last flag passes through
  task automatic test_reset_defaults();
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
  endtask

  // Single newest-pixel tap: rounding at 15/16, negative floor, pass-through
  task automatic test_pass_through_rounding();
    drain_pipe();
    set_kernel('0, '0, pack_row(0, 0, 1));
    write_reg(REG_LWIDTH, 24'd4);
    send_pixel(8'd15, 1'b0);
    send_pixel(8'd16, 1'b0);
    send_pixel(8'd255, 1'b0);
    drain_pipe();
    write_reg(REG_KROW2, pack_row(0, 0, -1));
    send_pixel(8'd1, 1'b0);
    drain_pipe();
    write_reg(REG_KROW2, pack_row(0, 0, 16));
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b1);
  endtask

  // Extreme coefficients drive the clamp at both ends
  task automatic test_saturation();
    drain_pipe();
    set_kernel(pack_row(127, 127, 127), pack_row(127, 127, 127), pack_row(127, 127, 127));
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    drain_pipe();
    set_kernel(pack_row(-128, -128, -128), pack_row(-128, -128, -128),
               pack_row(-128, -128, -128));
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b1);
  endtask

  // Widths below the minimum and above the maximum act as the limits
  task automatic test_width_limits();
    drain_pipe();
    set_kernel(pack_row(0, 0, 8), '0, pack_row(0, 0, 8));
    write_reg(REG_LWIDTH, 24'd0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd100, 1'b0);
    drain_pipe();
    write_reg(REG_LWIDTH, 24'hFFF803);
    send_pixel(8'd50, 1'b0);
    drain_pipe();
    write_reg(REG_LWIDTH, 24'd2047);
    send_pixel(8'd250, 1'b0);
    send_pixel(8'd10, 1'b0);
    drain_pipe();
    write_reg(REG_LWIDTH, 24'd1025);
    send_pixel(8'd77, 1'b1);
  endtask

  // Shrink the width while the pointer sits past the new store length
  task automatic test_width_change();
    drain_pipe();
    write_reg(REG_LWIDTH, 24'd20);
    do send_pixel(8'($urandom), 1'b0); while (rd_ptr < 5);
    drain_pipe();
    write_reg(REG_LWIDTH, 24'd6);
    send_pixel(8'($urandom), 1'b0);
    send_pixel(8'($urandom), 1'b1);
  endtask

  task automatic test_random_phases();
    int budget, n;
    logic [WIDTH_W-1:0] w;
    budget = 750;
    while (budget > 0) begin
      n = $urandom_range(20, 120);
      if (n > budget) n = budget;
      case ($urandom_range(0, 9))
        0:       w = 11'($urandom_range(0, 3));
        1:       w = 11'($urandom_range(1025, 2047));
        2, 3:    w = 11'($urandom_range(41, 300));
        default: w = 11'($urandom_range(4, 40));
      endcase
      run_phase(n, w, $urandom_range(0, 3) != 0);
      budget -= n;
    end
  endtask

  // Full width, long enough for both line stores to wrap
  task automatic test_max_width_wrap();
    run_phase(1100, 11'd1024, 1'b1);
  endtask

  // Back-to-back beats with no idling on either side
  task automatic test_steady_stream();
    run_phase(150, 11'($urandom_range(4, 64)), 1'b0);
  endtask

  // Output stall: random bursts while idling is on
  always @(negedge clk_i) begin
    if (!idle_en) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted output beat with the oldest prediction
  always @(posedge clk_i) begin
    px_beat_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_px.size() == 0) begin
        $error("unexpected beat: pixel_out %0d last_out %0d", pixel_out_o, last_out_o);
        fail_cnt++;
      end else begin
        exp_b = pending_px.pop_front();
        results_seen++;
        if (pixel_out_o !== exp_b.pix) begin
          $error("pixel_out mismatch: expected %0d, actual %0d", exp_b.pix, pixel_out_o);
          fail_cnt++;
        end
        if (last_out_o !== exp_b.last) begin
          $error("last_out mismatch: expected %0d, actual %0d", exp_b.last, last_out_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < WIN_SIZE; i++) win_px[i] = '0;
    for (int i = 0; i < STORE_LEN; i++) begin
      row_store0[i] = '0;
      row_store1[i] = '0;
    end
    for (int r = 0; r < KERNEL_DIM; r++) kern_row[r] = '0;
    rd_ptr    = 0;
    img_width = WIDTH_W'(LINE_WIDTH_RST);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_pass_through_rounding();
    test_saturation();
    test_width_limits();
    test_width_change();
    test_random_phases();
    test_max_width_wrap();
    test_steady_stream();

    drain_pipe();
    repeat (8) @(negedge clk_i);
    if (pending_px.size() != 0) begin
      $error("%0d predicted beats never came out", pending_px.size());
      fail_cnt++;
    end

    $display("Sent %0d pixels over %0d random phases plus directed cases", items_sent, phases);
    $display("Checked %0d filtered beats; widths clamped low/high, kernels at extremes",
             results_seen);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop if the stream hangs
  initial begin
    #4_000_000;
    $display("timeout with %0d beats outstanding", pending_px.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
